// ----- src/tdt_pkg.sv -----
// ----------------------------------------------------------------------------
// tdt_pkg
// Shared types and constants of the Trickle timer block: operation codes,
// register indexes, reset values, divider sizing and controller/datapath
// command and status structs.
// ----------------------------------------------------------------------------
package tdt_pkg;

	// operation codes of an input item
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_HEARD = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLINGS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANCY   = 2'd2;

	// register reset values
	localparam logic [4:0] RST_INTERVAL_MIN = 5'd12;
	localparam logic [4:0] RST_DOUBLINGS    = 5'd8;
	localparam logic [7:0] RST_REDUNDANCY   = 8'd10;

	// field widths
	localparam int EXP_W   = 5;
	localparam int HEARD_W = 8;
	localparam int RAND_W  = 16;
	localparam int CNTD_W  = 32;
	localparam int TICKS_W = CNTD_W + 1;

	// milliseconds per second, divisor of the interval conversion
	localparam logic [RAND_W-1:0] MS_PER_SEC = 16'd1000;

	// shared divider: 48-bit dividend, 16-bit divisor, 4 quotient bits a cycle
	localparam int DIV_W      = 48;
	localparam int DVS_W      = 16;
	localparam int DIV_RADIX  = 4;
	localparam int DIV_STEPS  = DIV_W / DIV_RADIX;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

	// controller to datapath commands
	typedef struct packed {
		logic latch;     // capture the accepted input transaction
		logic eval;      // apply the operation, load the divider if drawing
		logic div_step;  // one radix-16 divider step
		logic mul;       // keep ticks and half, form half * rand
		logic commit;    // store transmit point and rest of interval
		logic out_load;  // load the output register
	} tdt_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_draw; // current operation draws a new interval
	} tdt_status_t;

endpackage

// ----- src/tdt_if.sv -----
// ----------------------------------------------------------------------------
// tdt_in_if / tdt_out_if
// Valid/ready channels of the Trickle timer: the item channel carrying
// operations and the result channel carrying timer decisions.
// ----------------------------------------------------------------------------
interface tdt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] rand_value;
	logic        addr_ready;

	modport source (output valid, output op, output rand_value, output addr_ready,
		input ready);
	modport sink (input valid, input op, input rand_value, input addr_ready,
		output ready);
endinterface

interface tdt_out_if;
	logic       valid;
	logic       ready;
	logic       send_msg;
	logic       suppressed;
	logic [4:0] interval_exponent;
	logic [7:0] heard_count;

	modport source (output valid, output send_msg, output suppressed,
		output interval_exponent, output heard_count, input ready);
	modport sink (input valid, input send_msg, input suppressed,
		input interval_exponent, input heard_count, output ready);
endinterface

// ----- src/tdt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdt_ctrl
// Sequencer of the Trickle timer: accepts a transaction, runs the evaluate,
// divide, multiply, divide, commit sequence when an interval is drawn, and
// owns the output register valid.
// ----------------------------------------------------------------------------
module tdt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  tdt_pkg::tdt_status_t st,
	output tdt_pkg::tdt_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_TDIV = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_PDIV = 3'd4;
	localparam logic [2:0] S_FIN  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	localparam logic [tdt_pkg::DIV_CNT_W-1:0] CNT_LAST =
		tdt_pkg::DIV_CNT_W'(tdt_pkg::DIV_STEPS - 1);

	logic [2:0]                    state_q, state_nx;
	logic [tdt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          out_valid_q;
	logic                          cnt_last;

	assign cnt_last  = (cnt_q == CNT_LAST);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nx  = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = st.need_draw ? S_TDIV : S_OUT;
			end
			S_TDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last)
					state_nx = S_MUL;
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = S_PDIV;
			end
			S_PDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_last)
					state_nx = S_FIN;
			end
			S_FIN: begin
				cmd.commit = 1'b1;
				state_nx   = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// state, divider step count, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_step && !cnt_last)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/tdt_dpath.sv -----
// ----------------------------------------------------------------------------
// tdt_dpath
// Datapath of the Trickle timer: configuration registers, timer state,
// a shared radix-16 divider, one 32x16 multiplier and the output register.
// ----------------------------------------------------------------------------
module tdt_dpath #(
	parameter int unsigned TICKS_PER_SECOND = 128,
	parameter int unsigned RAND_RANGE_MAX   = 65535
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tdt_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tdt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  tdt_pkg::tdt_cmd_t                 cmd,
	output tdt_pkg::tdt_status_t              st,
	input  logic [1:0]                        op,
	input  logic [tdt_pkg::RAND_W-1:0]        rand_value,
	input  logic                              addr_ready,
	output logic                              send_msg,
	output logic                              suppressed,
	output logic [tdt_pkg::EXP_W-1:0]         interval_exponent,
	output logic [tdt_pkg::HEARD_W-1:0]       heard_count
);

	localparam logic [10:0] TPS_V = 11'(TICKS_PER_SECOND);
	localparam logic [tdt_pkg::RAND_W-1:0] RRM_V = tdt_pkg::RAND_W'(RAND_RANGE_MAX);

	// configuration
	logic [tdt_pkg::EXP_W-1:0]   int_min_q;
	logic [tdt_pkg::EXP_W-1:0]   doub_q;
	logic [tdt_pkg::HEARD_W-1:0] redund_q;

	// timer state
	logic [tdt_pkg::EXP_W-1:0]   cur_exp_q;
	logic [tdt_pkg::HEARD_W-1:0] heard_q;
	logic                        in_send_q;
	logic [tdt_pkg::CNTD_W-1:0]  countdown_q;
	logic [tdt_pkg::CNTD_W-1:0]  rest_q;
	logic                        addr_ok_q;
	logic                        running_q;

	// captured transaction and per-item flags
	logic [1:0]                  op_q;
	logic [tdt_pkg::RAND_W-1:0]  rnd_q;
	logic                        ready_q;
	logic                        send_q;
	logic                        supp_q;

	// divider and interval arithmetic
	logic [tdt_pkg::DVS_W-1:0]   rem_q;
	logic [tdt_pkg::DIV_W-1:0]   quo_q;
	logic [tdt_pkg::DVS_W-1:0]   dvs_q;
	logic [tdt_pkg::TICKS_W-1:0] ticks_q;
	logic [tdt_pkg::CNTD_W-1:0]  half_q;

	logic [tdt_pkg::CNTD_W-1:0]  cd_dec;
	logic                        fire;
	logic                        proceed;
	logic [tdt_pkg::EXP_W:0]     lim_sum;
	logic [tdt_pkg::EXP_W-1:0]   limit;
	logic [tdt_pkg::EXP_W-1:0]   exp_bump;
	logic                        start_draw;
	logic                        tick_draw;
	logic                        need_draw;
	logic [tdt_pkg::EXP_W-1:0]   exp_draw;
	logic                        below;
	logic [tdt_pkg::RAND_W-1:0]  rnd_cl;
	logic [tdt_pkg::DIV_W-1:0]   prod;
	logic [tdt_pkg::TICKS_W-1:0] point;
	logic [tdt_pkg::TICKS_W-1:0] rest_calc;
	logic [tdt_pkg::DVS_W-1:0]   rem_nx;
	logic [tdt_pkg::DIV_W-1:0]   quo_nx;

	// operation decode
	assign cd_dec     = (countdown_q != '0) ? countdown_q - 1'b1 : '0;
	assign fire       = (op_q == tdt_pkg::OP_TICK) && running_q && (cd_dec == '0);
	assign proceed    = fire && (addr_ok_q || ready_q);
	assign lim_sum    = {1'b0, int_min_q} + {1'b0, doub_q};
	assign limit      = lim_sum[tdt_pkg::EXP_W] ? '1 : lim_sum[tdt_pkg::EXP_W-1:0];
	assign exp_bump   = (cur_exp_q < limit) ? cur_exp_q + 1'b1 : cur_exp_q;
	assign start_draw = (op_q == tdt_pkg::OP_START) &&
		(!running_q || (cur_exp_q > int_min_q));
	assign tick_draw  = proceed && !in_send_q;
	assign need_draw  = tick_draw || start_draw;
	assign exp_draw   = start_draw ? int_min_q : exp_bump;
	assign below      = (heard_q < redund_q);
	assign st.need_draw = need_draw;

	// transmit point arithmetic
	assign rnd_cl    = (rnd_q > RRM_V) ? RRM_V : rnd_q;
	assign prod      = quo_q[tdt_pkg::CNTD_W:1] * rnd_cl;
	assign point     = {1'b0, half_q} + {1'b0, quo_q[tdt_pkg::CNTD_W-1:0]};
	assign rest_calc = ticks_q - point;

	// four restoring division steps per cycle
	always_comb begin
		logic [tdt_pkg::DVS_W-1:0] r;
		logic [tdt_pkg::DIV_W-1:0] q;
		logic [tdt_pkg::DVS_W:0]   t;
		r = rem_q;
		q = quo_q;
		for (int i = 0; i < tdt_pkg::DIV_RADIX; i++) begin
			t = {r, q[tdt_pkg::DIV_W-1]};
			q = {q[tdt_pkg::DIV_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t    = t - {1'b0, dvs_q};
				q[0] = 1'b1;
			end
			r = t[tdt_pkg::DVS_W-1:0];
		end
		rem_nx = r;
		quo_nx = q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_min_q <= tdt_pkg::RST_INTERVAL_MIN;
			doub_q    <= tdt_pkg::RST_DOUBLINGS;
			redund_q  <= tdt_pkg::RST_REDUNDANCY;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tdt_pkg::CFG_INTERVAL_MIN: int_min_q <= cfg_wdata[tdt_pkg::EXP_W-1:0];
				tdt_pkg::CFG_DOUBLINGS:    doub_q    <= cfg_wdata[tdt_pkg::EXP_W-1:0];
				tdt_pkg::CFG_REDUNDANCY:   redund_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_exp_q   <= '0;
			heard_q     <= '0;
			in_send_q   <= 1'b0;
			countdown_q <= '0;
			rest_q      <= '0;
			addr_ok_q   <= 1'b0;
			running_q   <= 1'b0;
		end else if (cmd.eval) begin
			unique case (op_q)
				tdt_pkg::OP_TICK: begin
					if (running_q) begin
						countdown_q <= cd_dec;
						if (fire && !proceed)
							countdown_q <= tdt_pkg::CNTD_W'(TPS_V);
						else if (proceed) begin
							addr_ok_q <= 1'b1;
							if (in_send_q) begin
								in_send_q   <= 1'b0;
								countdown_q <= rest_q;
							end
						end
					end
				end
				tdt_pkg::OP_HEARD: begin
					if (heard_q != '1)
						heard_q <= heard_q + 1'b1;
				end
				tdt_pkg::OP_START: begin
					running_q <= 1'b1;
				end
				default: ;
			endcase
			if (need_draw)
				cur_exp_q <= exp_draw;
		end else if (cmd.commit) begin
			countdown_q <= point[tdt_pkg::CNTD_W-1:0];
			rest_q      <= rest_calc[tdt_pkg::CNTD_W-1:0];
			in_send_q   <= 1'b1;
			heard_q     <= '0;
		end
	end

	// transaction capture, arithmetic and output registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			rnd_q   <= rand_value;
			ready_q <= addr_ready;
		end
		if (cmd.eval) begin
			send_q <= proceed && in_send_q && below;
			supp_q <= proceed && in_send_q && !below;
		end
		// interval in ticks: (TPS << exp) / 1000
		if (cmd.eval && need_draw) begin
			quo_q <= tdt_pkg::DIV_W'(TPS_V) << exp_draw;
			rem_q <= '0;
			dvs_q <= tdt_pkg::MS_PER_SEC;
		end else if (cmd.div_step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end else if (cmd.mul) begin
			// offset into the second half: (half * rand) / range
			ticks_q <= quo_q[tdt_pkg::TICKS_W-1:0];
			half_q  <= quo_q[tdt_pkg::CNTD_W:1];
			quo_q   <= prod;
			rem_q   <= '0;
			dvs_q   <= RRM_V;
		end
		if (cmd.out_load) begin
			send_msg          <= send_q;
			suppressed        <= supp_q;
			interval_exponent <= cur_exp_q;
			heard_count       <= heard_q;
		end
	end

endmodule

// ----- src/trickle_dio_timer_top.sv -----
// ----------------------------------------------------------------------------
// trickle_dio_timer_top
// Trickle timer stepped by tick, heard and reset/start transactions, with a
// plain register write port for interval_min, doublings and redundancy.
// ----------------------------------------------------------------------------
// One transaction is worked at a time and each gives exactly one result. A
// transaction that draws no new interval (heard, unused, a tick that ends no
// interval, or a reset/start that changes nothing) goes from acceptance
// through evaluate to the output load and back to idle. A transaction that
// draws a new interval (reset/start, or a tick ending an interval) runs an
// evaluate step, the shared radix-16 divider to convert the interval to
// ticks, a multiply step, the divider again to scale the random transmit
// point, a commit step, then the output load and the return to idle.
// The result sits in an output register, so the next
// transaction is accepted while it waits to be taken; that next transaction
// then holds before its output load until the earlier result is taken.
// The user must write the registers only while the block is idle; the block itself does not enforce it.
module trickle_dio_timer_top #(
	parameter int unsigned TICKS_PER_SECOND = 128,
	parameter int unsigned RAND_RANGE_MAX   = 65535
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tdt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [tdt_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tdt_in_if.sink                         item,
	tdt_out_if.source                      result
);

	tdt_pkg::tdt_cmd_t    cmd;
	tdt_pkg::tdt_status_t st;

	// sequencer
	tdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.st        (st),
		.cmd       (cmd)
	);

	// state and arithmetic
	tdt_dpath #(
		.TICKS_PER_SECOND (TICKS_PER_SECOND),
		.RAND_RANGE_MAX   (RAND_RANGE_MAX)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.cmd               (cmd),
		.st                (st),
		.op                (item.op),
		.rand_value        (item.rand_value),
		.addr_ready        (item.addr_ready),
		.send_msg          (result.send_msg),
		.suppressed        (result.suppressed),
		.interval_exponent (result.interval_exponent),
		.heard_count       (result.heard_count)
	);

`ifndef SYNTHESIS
	// one transaction at a time: no acceptance right after one
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("transaction accepted while previous one in progress");

	// a transmit point is either sent or suppressed, never both
	a_send_xor_supp: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.send_msg && result.suppressed))
		else $error("send and suppressed both set");

	// a loaded result is presented on the next cycle
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result.valid)
		else $error("output register loaded but not valid");

	// the divider never steps and nothing commits while the block waits for a transaction
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !cmd.div_step && !cmd.commit)
		else $error("divider active while idle");
`endif

endmodule
